[design/cpt_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the closest-point-on-triangle pipeline.
// No dependencies.
package cpt_pkg;

  localparam int CPT_COORD_WIDTH = 32;
  // operand slice width of the partial-product multiplier
  localparam int CPT_MUL_CHUNK = 32;

  typedef enum logic [2:0] {
    REG_A    = 3'd0,
    REG_B    = 3'd1,
    REG_C    = 3'd2,
    REG_AB   = 3'd3,
    REG_BC   = 3'd4,
    REG_CA   = 3'd5,
    REG_FACE = 3'd6
  } region_t;

  typedef struct packed {
    region_t region;
    logic    degen;
    logic    corner;
  } sel_ctl_t;

endpackage

[design/cpt_delay.sv]
`timescale 1ns / 1ps
// Stallable shift line for payload that rides alongside the datapath.
// Depends on nothing.
module cpt_delay #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] taps [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= din;
      for (int i = 1; i < DEPTH; i++) taps[i] <= taps[i-1];
    end
  end

  assign dout = taps[DEPTH-1];

endmodule

[design/cpt_mul.sv]
`timescale 1ns / 1ps
// Signed multiplier built from registered 32x32 partial products and a registered output.
// Depends on cpt_pkg.
module cpt_mul import cpt_pkg::*; #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [BW-1:0] b,
  output logic signed [AW+BW-1:0] p
);

  localparam int CH  = CPT_MUL_CHUNK;
  localparam int NA  = (AW + CH - 1) / CH;
  localparam int NB  = (BW + CH - 1) / CH;
  localparam int ACW = (NA + NB) * CH;

  logic [NA*CH-1:0] ua;
  logic [NB*CH-1:0] ub;
  logic [2*CH-1:0]  pp [NA][NB];
  logic             neg;
  logic [ACW-1:0]   acc;

  always_comb begin
    ua = (NA*CH)'(a[AW-1] ? AW'(-a) : AW'(a));
    ub = (NB*CH)'(b[BW-1] ? BW'(-b) : BW'(b));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++)
        for (int j = 0; j < NB; j++)
          pp[i][j] <= ua[i*CH +: CH] * ub[j*CH +: CH];
      neg <= a[AW-1] ^ b[BW-1];
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < NA; i++)
      for (int j = 0; j < NB; j++)
        acc = acc + (ACW'(pp[i][j]) << ((i + j) * CH));
  end

  always_ff @(posedge clk) begin
    if (en) p <= neg ? -$signed((AW+BW)'(acc)) : $signed((AW+BW)'(acc));
  end

endmodule

[design/cpt_div.sv]
`timescale 1ns / 1ps
// Pipelined restoring divider: round(n/d), ties away from zero, one quotient
// bit per stage, with an overflow flag when |q| needs more than QW bits.
// Depends on nothing.
module cpt_div #(
  parameter int NW = 64,
  parameter int DW = 64,
  parameter int QW = 33
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] n,
  input  logic signed [DW-1:0] d,
  output logic [QW-1:0]        q,
  output logic                 neg,
  output logic                 ovf
);

  localparam int MW = (NW > DW) ? NW : DW;
  localparam int RW = MW + QW + 2;

  logic [NW-1:0] un;
  logic [DW-1:0] ud;
  logic          neg0;

  logic [RW-1:0] r_pipe   [QW+1];
  logic [RW-1:0] d_pipe   [QW+1];
  logic [QW-1:0] q_pipe   [QW+1];
  logic          neg_pipe [QW+1];
  logic          ovf_pipe [QW+1];

  logic [RW-1:0] n2;
  logic [RW-1:0] d2;

  always_ff @(posedge clk) begin
    if (en) begin
      un   <= n[NW-1] ? NW'(-n) : NW'(n);
      ud   <= d[DW-1] ? DW'(-d) : DW'(d);
      neg0 <= n[NW-1] ^ d[DW-1];
    end
  end

  // rounding: floor((2|n| + |d|) / 2|d|)
  always_comb begin
    n2 = (RW'(un) << 1) + RW'(ud);
    d2 = RW'(ud) << 1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_pipe[0]   <= n2;
      d_pipe[0]   <= d2;
      q_pipe[0]   <= '0;
      neg_pipe[0] <= neg0;
      ovf_pipe[0] <= n2 >= (d2 << QW);
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_step
    localparam int BIT = QW - 1 - j;
    logic [RW-1:0] trial;
    logic          take;
    assign trial = d_pipe[j] << BIT;
    assign take  = r_pipe[j] >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        r_pipe[j+1]   <= take ? r_pipe[j] - trial : r_pipe[j];
        d_pipe[j+1]   <= d_pipe[j];
        q_pipe[j+1]   <= q_pipe[j] | (take ? (QW'(1) << BIT) : '0);
        neg_pipe[j+1] <= neg_pipe[j];
        ovf_pipe[j+1] <= ovf_pipe[j];
      end
    end
  end

  assign q   = q_pipe[QW];
  assign neg = neg_pipe[QW];
  assign ovf = ovf_pipe[QW];

endmodule

[design/closest_point_on_triangle_unit.sv]
`timescale 1ns / 1ps
// Channel | dir | fields (low bit up)
// s_*     | in  | tdata: ax ay az bx by_coord bz cx cy cz px py pz
// m_*     | out | tdata: qx qy qz; tuser: region[2:0] degenerate[3]
//
// Fully pipelined: one transaction per cycle while the output is not stalled;
// the pipe is built from the bit-per-stage divider (COORD_WIDTH+3 stages)
// and three two-stage partial-product multiplier rows.
// rst clears the valid bits only. A stalled output freezes the whole pipe;
// s_tready follows !m_tvalid || m_tready.
// Depends on cpt_pkg, cpt_mul, cpt_div, cpt_delay.
module closest_point_on_triangle_unit import cpt_pkg::*; #(
  parameter int COORD_WIDTH = CPT_COORD_WIDTH
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // ax, ay, az, bx, by_coord, bz, cx, cy, cz, px, py, pz
  input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // qx, qy, qz
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // region[2:0], degenerate[3]
  output logic [3:0] m_tuser
);

  localparam int W    = COORD_WIDTH;
  localparam int W1   = W + 1;
  localparam int PW   = 2 * W1;
  localparam int DW   = PW + 2;
  localparam int CW   = 2 * DW;
  localparam int VW   = CW + 1;
  localparam int NDW  = VW + 2;
  localparam int NPW  = W1 + VW;
  localparam int NW   = NPW + 1;
  localparam int QW   = W + 1;
  localparam int LDIV = QW + 2;
  localparam int TOT  = 12 + LDIV;
  localparam int OW   = ((3*W+7)/8)*8;
  localparam int SW   = W + 3;
  localparam int CTW  = 3*W + $bits(sel_ctl_t);

  logic           en;
  logic [TOT-1:0] v;

  assign en       = !v[TOT-1] || m_tready;
  assign s_tready = en;
  assign m_tvalid = v[TOT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[TOT-2:0], s_tvalid};
    end
  end

  // ---- capture and edge vectors
  logic signed [W-1:0]  fa [3], fb [3], fc [3], fp [3];
  logic signed [W-1:0]  a1 [3], b1 [3], c1 [3];
  logic signed [W1-1:0] dl [2][3];
  logic signed [W1-1:0] dr [3][3];
  logic signed [W1-1:0] bc1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fa[i] = $signed(s_tdata[i*W +: W]);
      fb[i] = $signed(s_tdata[(3+i)*W +: W]);
      fc[i] = $signed(s_tdata[(6+i)*W +: W]);
      fp[i] = $signed(s_tdata[(9+i)*W +: W]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i]    <= fa[i];
        b1[i]    <= fb[i];
        c1[i]    <= fc[i];
        dl[0][i] <= W1'(fb[i]) - W1'(fa[i]);
        dl[1][i] <= W1'(fc[i]) - W1'(fa[i]);
        dr[0][i] <= W1'(fp[i]) - W1'(fa[i]);
        dr[1][i] <= W1'(fp[i]) - W1'(fb[i]);
        dr[2][i] <= W1'(fp[i]) - W1'(fc[i]);
        bc1[i]   <= W1'(fc[i]) - W1'(fb[i]);
      end
    end
  end

  // ---- dot products d1..d6
  logic signed [PW-1:0] pdot [6][3];
  logic signed [DW-1:0] dd [6];

  for (genvar k = 0; k < 6; k++) begin : g_dot
    for (genvar i = 0; i < 3; i++) begin : g_ax
      cpt_mul #(.AW(W1), .BW(W1)) u_mul (
        .clk(clk), .en(en), .a(dl[k%2][i]), .b(dr[k/2][i]), .p(pdot[k][i])
      );
    end
    always_ff @(posedge clk) begin
      if (en) dd[k] <= DW'(pdot[k][0]) + DW'(pdot[k][1]) + DW'(pdot[k][2]);
    end
  end

  // ---- cross terms
  logic signed [CW-1:0] cr [6];
  logic signed [VW-1:0] vcr, vbr, var_t;

  cpt_mul #(.AW(DW), .BW(DW)) u_cr0 (.clk(clk), .en(en), .a(dd[0]), .b(dd[3]), .p(cr[0]));
  cpt_mul #(.AW(DW), .BW(DW)) u_cr1 (.clk(clk), .en(en), .a(dd[2]), .b(dd[1]), .p(cr[1]));
  cpt_mul #(.AW(DW), .BW(DW)) u_cr2 (.clk(clk), .en(en), .a(dd[4]), .b(dd[1]), .p(cr[2]));
  cpt_mul #(.AW(DW), .BW(DW)) u_cr3 (.clk(clk), .en(en), .a(dd[0]), .b(dd[5]), .p(cr[3]));
  cpt_mul #(.AW(DW), .BW(DW)) u_cr4 (.clk(clk), .en(en), .a(dd[2]), .b(dd[5]), .p(cr[4]));
  cpt_mul #(.AW(DW), .BW(DW)) u_cr5 (.clk(clk), .en(en), .a(dd[4]), .b(dd[3]), .p(cr[5]));

  always_ff @(posedge clk) begin
    if (en) begin
      vcr   <= VW'(cr[0]) - VW'(cr[1]);
      vbr   <= VW'(cr[2]) - VW'(cr[3]);
      var_t <= VW'(cr[4]) - VW'(cr[5]);
    end
  end

  // ---- side payload to the decision stage
  logic [6*DW-1:0] d_pk_in, d_pk7;
  logic [9*W1-1:0] e_pk_in, e_pk7;
  logic [9*W-1:0]  c_pk_in, c_pk7;

  always_comb begin
    for (int k = 0; k < 6; k++) d_pk_in[k*DW +: DW] = dd[k];
    for (int i = 0; i < 3; i++) begin
      e_pk_in[i*W1 +: W1]     = dl[0][i];
      e_pk_in[(3+i)*W1 +: W1] = dl[1][i];
      e_pk_in[(6+i)*W1 +: W1] = bc1[i];
      c_pk_in[i*W +: W]       = a1[i];
      c_pk_in[(3+i)*W +: W]   = b1[i];
      c_pk_in[(6+i)*W +: W]   = c1[i];
    end
  end

  cpt_delay #(.WIDTH(6*DW), .DEPTH(3)) u_dly_d (.clk(clk), .en(en), .din(d_pk_in), .dout(d_pk7));
  cpt_delay #(.WIDTH(9*W1), .DEPTH(6)) u_dly_e (.clk(clk), .en(en), .din(e_pk_in), .dout(e_pk7));
  cpt_delay #(.WIDTH(9*W), .DEPTH(6)) u_dly_c (.clk(clk), .en(en), .din(c_pk_in), .dout(c_pk7));

  // ---- region decision
  logic signed [DW-1:0]  d1, d2, d3, d4, d5, d6;
  logic signed [DW:0]    e43, e56;
  logic signed [W1-1:0]  ab7 [3], ac7 [3], bc7 [3];
  logic signed [W-1:0]   a7 [3], b7 [3], c7 [3];
  logic signed [W1-1:0]  x_n [3], y_n [3];
  logic signed [VW-1:0]  m_n, k_n;
  logic signed [NDW-1:0] den_n;
  logic signed [W-1:0]   base_n [3];
  sel_ctl_t              ctl_n;

  always_comb begin
    d1 = $signed(d_pk7[0*DW +: DW]);
    d2 = $signed(d_pk7[1*DW +: DW]);
    d3 = $signed(d_pk7[2*DW +: DW]);
    d4 = $signed(d_pk7[3*DW +: DW]);
    d5 = $signed(d_pk7[4*DW +: DW]);
    d6 = $signed(d_pk7[5*DW +: DW]);
    for (int i = 0; i < 3; i++) begin
      ab7[i] = $signed(e_pk7[i*W1 +: W1]);
      ac7[i] = $signed(e_pk7[(3+i)*W1 +: W1]);
      bc7[i] = $signed(e_pk7[(6+i)*W1 +: W1]);
      a7[i]  = $signed(c_pk7[i*W +: W]);
      b7[i]  = $signed(c_pk7[(3+i)*W +: W]);
      c7[i]  = $signed(c_pk7[(6+i)*W +: W]);
    end
    e43 = (DW+1)'(d4) - (DW+1)'(d3);
    e56 = (DW+1)'(d5) - (DW+1)'(d6);
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      x_n[i]    = '0;
      y_n[i]    = '0;
      base_n[i] = a7[i];
    end
    m_n          = '0;
    k_n          = '0;
    den_n        = '0;
    ctl_n.region = REG_FACE;
    ctl_n.degen  = 1'b0;
    ctl_n.corner = 1'b1;
    if (d1 <= 0 && d2 <= 0) begin
      ctl_n.region = REG_A;
    end else if (d3 >= 0 && d4 <= d3) begin
      ctl_n.region = REG_B;
      for (int i = 0; i < 3; i++) base_n[i] = b7[i];
    end else if (vcr <= 0 && d1 >= 0 && d3 <= 0) begin
      ctl_n.region = REG_AB;
      for (int i = 0; i < 3; i++) x_n[i] = ab7[i];
      m_n          = VW'(d1);
      den_n        = NDW'(d1) - NDW'(d3);
      ctl_n.corner = den_n == 0;
    end else if (d6 >= 0 && d5 <= d6) begin
      ctl_n.region = REG_C;
      for (int i = 0; i < 3; i++) base_n[i] = c7[i];
    end else if (vbr <= 0 && d2 >= 0 && d6 <= 0) begin
      ctl_n.region = REG_CA;
      for (int i = 0; i < 3; i++) x_n[i] = ac7[i];
      m_n          = VW'(d2);
      den_n        = NDW'(d2) - NDW'(d6);
      ctl_n.corner = den_n == 0;
    end else if (var_t <= 0 && e43 >= 0 && e56 >= 0) begin
      ctl_n.region = REG_BC;
      for (int i = 0; i < 3; i++) begin
        x_n[i]    = bc7[i];
        base_n[i] = b7[i];
      end
      m_n          = VW'(e43);
      den_n        = NDW'(e43) + NDW'(e56);
      ctl_n.corner = den_n == 0;
    end else begin
      for (int i = 0; i < 3; i++) begin
        x_n[i] = ab7[i];
        y_n[i] = ac7[i];
      end
      m_n          = vbr;
      k_n          = vcr;
      den_n        = NDW'(var_t) + NDW'(vbr) + NDW'(vcr);
      ctl_n.corner = den_n == 0;
      ctl_n.degen  = den_n == 0;
    end
  end

  logic signed [W1-1:0]  sx [3], sy [3];
  logic signed [VW-1:0]  sm, sk;
  logic signed [NDW-1:0] sden;
  logic [CTW-1:0]        sctl_pk;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sx[i] <= x_n[i];
        sy[i] <= y_n[i];
      end
      sm      <= m_n;
      sk      <= k_n;
      sden    <= den_n;
      sctl_pk <= {base_n[2], base_n[1], base_n[0], ctl_n};
    end
  end

  // ---- projection numerators
  logic signed [NPW-1:0] pnx [3], pny [3];
  logic signed [NW-1:0]  num [3];

  for (genvar i = 0; i < 3; i++) begin : g_num
    cpt_mul #(.AW(W1), .BW(VW)) u_mx (.clk(clk), .en(en), .a(sx[i]), .b(sm), .p(pnx[i]));
    cpt_mul #(.AW(W1), .BW(VW)) u_my (.clk(clk), .en(en), .a(sy[i]), .b(sk), .p(pny[i]));
    always_ff @(posedge clk) begin
      if (en) num[i] <= NW'(pnx[i]) + NW'(pny[i]);
    end
  end

  logic [NDW-1:0] den_pk11;
  logic [CTW-1:0] ctl_pk_out;

  cpt_delay #(.WIDTH(NDW), .DEPTH(3)) u_dly_den (
    .clk(clk), .en(en), .din(sden), .dout(den_pk11)
  );
  cpt_delay #(.WIDTH(CTW), .DEPTH(3 + LDIV)) u_dly_ctl (
    .clk(clk), .en(en), .din(sctl_pk), .dout(ctl_pk_out)
  );

  // ---- division
  logic [QW-1:0] quo [3];
  logic          qneg [3], qovf [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    cpt_div #(.NW(NW), .DW(NDW), .QW(QW)) u_div (
      .clk(clk), .en(en), .n(num[i]), .d($signed(den_pk11)),
      .q(quo[i]), .neg(qneg[i]), .ovf(qovf[i])
    );
  end

  // ---- offset from base, saturate, output register
  sel_ctl_t            fctl;
  logic signed [W-1:0] fbase [3];
  logic signed [W-1:0] qres [3];
  logic signed [SW-1:0] qs [3], sum [3];
  logic signed [W-1:0] out_q [3];
  region_t             out_region;
  logic                out_degen;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    fctl = ctl_pk_out[$bits(sel_ctl_t)-1:0];
    for (int i = 0; i < 3; i++) begin
      fbase[i] = $signed(ctl_pk_out[$bits(sel_ctl_t) + i*W +: W]);
      qs[i]    = qneg[i] ? -$signed({2'b00, quo[i]}) : $signed({2'b00, quo[i]});
      sum[i]   = qs[i] + SW'(fbase[i]);
      if (fctl.corner) begin
        qres[i] = fbase[i];
      end else if (qovf[i]) begin
        qres[i] = qneg[i] ? $signed(MINV) : $signed(MAXV);
      end else if (sum[i][SW-1:W-1] == {(SW-W+1){1'b0}}
                   || sum[i][SW-1:W-1] == {(SW-W+1){1'b1}}) begin
        qres[i] = sum[i][W-1:0];
      end else begin
        qres[i] = sum[i][SW-1] ? $signed(MINV) : $signed(MAXV);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) out_q[i] <= qres[i];
      out_region <= fctl.region;
      out_degen  <= fctl.degen;
    end
  end

  assign m_tdata = OW'({out_q[2], out_q[1], out_q[0]});
  assign m_tuser = {out_degen, out_region};

endmodule

[design/cpt_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for closest_point_on_triangle_unit, bound to the top.
// Depends on cpt_pkg.
module cpt_assertions import cpt_pkg::*; #(
  parameter int COORD_WIDTH = CPT_COORD_WIDTH
) (
  input logic clk,
  input logic rst,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  input logic [3:0] m_tuser
);

  // a held result must stay offered
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // a held result must not change
  a_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // the pipe advances exactly when the output slot frees
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("input ready does not track output stall");

  a_degen: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[3] |-> m_tuser[2:0] == REG_FACE)
    else $error("degenerate flag outside face region");

  a_rst: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind closest_point_on_triangle_unit cpt_assertions #(.COORD_WIDTH(COORD_WIDTH)) u_cpt_assertions (
  .clk(clk), .rst(rst), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
);

[dv/cpt_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the closest-point-on-triangle unit: it predicts each query's
// result with exact wide integer math and compares the output stream in order.
// Depends on cpt_pkg.
module cpt_checker import cpt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [383:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [95:0]  m_tdata,
  input  logic [3:0]   m_tuser,
  output int           errors,
  output int           pending,
  output int           n_results,
  output int           n_degen,
  output int           n_saturated
);

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [31:0] q [3];
    region_t     region;
    logic        degen;
  } closest_t;

  localparam wide_t CMAX = 2147483647;
  localparam wide_t CMIN = -CMAX - 1;

  closest_t expected_q[$];
  int region_hits [7];

  function automatic wide_t dot3(input wide_t u0, u1, u2, v0, v1, v2);
    return u0 * v0 + u1 * v1 + u2 * v2;
  endfunction

  // n / d rounded to nearest, ties away from zero
  function automatic wide_t round_div(input wide_t n, input wide_t d);
    logic  neg;
    wide_t q;
    if (d < 0) begin
      d = -d;
      n = -n;
    end
    neg = n < 0;
    if (neg) n = -n;
    q = (2 * n + d) / (2 * d);
    return neg ? -q : q;
  endfunction

  function automatic logic [31:0] sat32(input wide_t x);
    if (x > CMAX) return 32'h7fff_ffff;
    if (x < CMIN) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic logic [31:0] edge_coord(input wide_t base, dir, num, den);
    if (den == 0) return sat32(base);
    return sat32(base + round_div(dir * num, den));
  endfunction

  function automatic closest_t closest_point(input logic [383:0] d);
    wide_t a[3], b[3], c[3], p[3], ab[3], ac[3], ap[3], bp[3], cp[3], bc[3];
    wide_t d1, d2, d3, d4, d5, d6, vc, vb, va, e43, e56, den;
    closest_t r;
    for (int i = 0; i < 3; i++) begin
      a[i] = $signed(d[32*i +: 32]);
      b[i] = $signed(d[32*(3+i) +: 32]);
      c[i] = $signed(d[32*(6+i) +: 32]);
      p[i] = $signed(d[32*(9+i) +: 32]);
      ab[i] = b[i] - a[i];
      ac[i] = c[i] - a[i];
      ap[i] = p[i] - a[i];
      bp[i] = p[i] - b[i];
      cp[i] = p[i] - c[i];
      bc[i] = c[i] - b[i];
    end
    r.degen = 1'b0;
    d1 = dot3(ab[0], ab[1], ab[2], ap[0], ap[1], ap[2]);
    d2 = dot3(ac[0], ac[1], ac[2], ap[0], ap[1], ap[2]);
    if (d1 <= 0 && d2 <= 0) begin
      for (int i = 0; i < 3; i++) r.q[i] = sat32(a[i]);
      r.region = REG_A;
      return r;
    end
    d3 = dot3(ab[0], ab[1], ab[2], bp[0], bp[1], bp[2]);
    d4 = dot3(ac[0], ac[1], ac[2], bp[0], bp[1], bp[2]);
    if (d3 >= 0 && d4 - d3 <= 0) begin
      for (int i = 0; i < 3; i++) r.q[i] = sat32(b[i]);
      r.region = REG_B;
      return r;
    end
    vc = d1 * d4 - d3 * d2;
    if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
      for (int i = 0; i < 3; i++) r.q[i] = edge_coord(a[i], ab[i], d1, d1 - d3);
      r.region = REG_AB;
      return r;
    end
    d5 = dot3(ab[0], ab[1], ab[2], cp[0], cp[1], cp[2]);
    d6 = dot3(ac[0], ac[1], ac[2], cp[0], cp[1], cp[2]);
    if (d6 >= 0 && d5 - d6 <= 0) begin
      for (int i = 0; i < 3; i++) r.q[i] = sat32(c[i]);
      r.region = REG_C;
      return r;
    end
    vb = d5 * d2 - d1 * d6;
    if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
      for (int i = 0; i < 3; i++) r.q[i] = edge_coord(a[i], ac[i], d2, d2 - d6);
      r.region = REG_CA;
      return r;
    end
    va = d3 * d6 - d5 * d4;
    e43 = d4 - d3;
    e56 = d5 - d6;
    if (va <= 0 && e43 >= 0 && e56 >= 0) begin
      for (int i = 0; i < 3; i++) r.q[i] = edge_coord(b[i], bc[i], e43, e43 + e56);
      r.region = REG_BC;
      return r;
    end
    r.region = REG_FACE;
    den = va + vb + vc;
    if (den == 0) begin
      for (int i = 0; i < 3; i++) r.q[i] = sat32(a[i]);
      r.degen = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++)
      r.q[i] = sat32(a[i] + round_div(ab[i] * vb + ac[i] * vc, den));
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, exp);
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, exp);
    errors++;
  endtask

  assign pending = expected_q.size();

  always @(posedge clk) begin
    closest_t e;
    if (rst) begin
      errors = 0;
      n_results = 0;
      n_degen = 0;
      n_saturated = 0;
    end else begin
      if (s_tvalid && s_tready) expected_q.insert(expected_q.size(), closest_point(s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_q.size() == 0) begin
          $display("[%0t] result transaction with nothing expected", $time);
          errors++;
        end else begin
          e = expected_q.pop_front();
          n_results++;
          if (e.degen) n_degen++;
          for (int i = 0; i < 3; i++)
            if (e.q[i] == 32'h7fff_ffff || e.q[i] == 32'h8000_0000) n_saturated++;
          for (int i = 0; i < 3; i++)
            if (m_tdata[32*i +: 32] !== e.q[i])
              report_mismatch($sformatf("q[%0d]", i), m_tdata[32*i +: 32], e.q[i]);
          if (m_tuser[2:0] !== e.region)
            report_mismatch("region", {29'd0, m_tuser[2:0]}, {29'd0, e.region});
          if (m_tuser[3] !== e.degen)
            report_mismatch("degenerate", {31'd0, m_tuser[3]}, {31'd0, e.degen});
        end
      end
    end
  end

endmodule

[dv/closest_point_on_triangle_unit_tb.sv]
`timescale 1ns / 1ps
// Stimulus and verdict for closest_point_on_triangle_unit: directed region and
// corner cases, then random queries under several idle/stall mixes.
// Depends on cpt_pkg, the unit RTL and cpt_checker.
module closest_point_on_triangle_unit_tb;
  import cpt_pkg::*;

  localparam int ONE = 65536;
  localparam int IDLE_LIMIT = 5000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [383:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [95:0]  m_tdata;
  logic [3:0]   m_tuser;

  int errors, pending, n_results, n_degen, n_saturated;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  closest_point_on_triangle_unit u_top (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser
  );

  cpt_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser,
    .errors, .pending, .n_results, .n_degen, .n_saturated
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  // called at a falling edge; returns at a falling edge
  task automatic send(input logic [383:0] d);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic query(input int ax, ay, az, bx, by_coord, bz,
                       input int cx, cy, cz, px, py, pz);
    send({pz, py, px, cz, cy, cx, bz, by_coord, bx, az, ay, ax});
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic int near_coord(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic random_query();
    int c[12];
    int kind;
    int span;
    kind = $urandom_range(99);
    span = ($urandom_range(3) == 0) ? 1 << 28 : 1 << 20;
    for (int i = 0; i < 12; i++)
      c[i] = (kind < 15) ? int'($urandom) : near_coord(span);
    if (kind >= 15 && kind < 25)
      for (int i = 0; i < 3; i++) c[6+i] = 2 * c[3+i] - c[i];   // collinear corners
    else if (kind >= 25 && kind < 32)
      for (int i = 0; i < 3; i++) c[3+i] = c[i];                // A and B coincide
    else if (kind >= 32 && kind < 36)
      for (int i = 0; i < 3; i++) c[9+i] = c[i];                // query on a corner
    query(c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7], c[8], c[9], c[10], c[11]);
  endtask

  initial begin
    int mx, mn;
    mx = 32'h7fff_ffff;
    mn = 32'h8000_0000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // unit right triangle in z=0, query in each region
    query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, -ONE, ONE);
    query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, 2*ONE, -ONE, 0);
    query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, 2*ONE, 0);
    query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/2, -ONE, 3);
    query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, -ONE);
    query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, -ONE, ONE/3, 7);
    query(0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE/4, ONE/4, ONE);
    // rounding ties and thirds on tiny triangles
    query(0, 0, 0, 3, 0, 0, 0, 3, 0, 1, 1, 5);
    query(0, 0, 0, 2, 0, 0, 0, 0, 2, 1, -1, 0);
    query(0, 0, 0, -3, 0, 0, 0, 0, -3, -1, 1, -1);
    // collinear and zero-area triangles
    query(0, 0, 0, ONE, ONE, 0, 2*ONE, 2*ONE, 0, ONE, 0, ONE);
    query(5, 5, 5, 5, 5, 5, 5, 5, 5, 9, -9, 1);
    query(0, 0, 0, 0, 0, 0, ONE, 0, 0, ONE/2, ONE, 0);
    query(0, 0, 0, 0, 0, 0, ONE, 0, 0, -ONE, 0, 0);
    // coordinate extremes and saturating projections
    query(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx);
    query(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn);
    query(mn, mn, mn, mx, mn, mn, mn, mx, mn, mx, mx, mx);
    query(mx, mx, 0, mn, mx, 0, mx, mn, 0, mn, mn, mx);
    query(mn, 0, mx, mx, 0, mn, 0, mx, 0, 0, 0, 0);
    query(mx, mn, mx, mn, mx, mn, 0, 0, 0, mn, mx, mn);
    query(-1, -1, -1, 1, 0, 0, 0, 1, 0, mx, mn, mx);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      for (int n = 0; n < 175; n++) random_query();
      drain();
    end
    stall_pct = 0;

    repeat (60) @(posedge clk);
    $display("checked %0d queries over four idle/stall mixes", n_results);
    $display("%0d degenerate faces, %0d saturated coordinates", n_degen, n_saturated);
    if (errors == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
